// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the Modbus response receiver.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising edge of clk, off while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check, also active during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/mbrx_pkg.sv -----
// Package for the Modbus RTU response receiver: field widths, codes,
// register reset values and the CRC-16 byte update. No dependencies.
package mbrx_pkg;

  localparam int ReadDataLenDefault  = 56;
  localparam int WriteDataLenDefault = 4;

  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 32;
  localparam int InDataW   = 40;
  localparam int OutDataW  = 32;

  // Register indexes
  localparam logic [CfgIndexW-1:0] REG_GAP_TIMEOUT    = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_DEVICE_ADDRESS = 2'd1;
  localparam logic [CfgIndexW-1:0] REG_EXPECTED_COUNT = 2'd2;
  localparam logic [CfgIndexW-1:0] REG_DEVICE_TYPE_OK = 2'd3;

  localparam logic [31:0] GAP_TIMEOUT_RESET    = 32'd10;
  localparam logic [7:0]  DEVICE_ADDRESS_RESET = 8'h01;
  localparam logic [7:0]  EXPECTED_COUNT_RESET = 8'h38;
  localparam logic        DEVICE_TYPE_OK_RESET = 1'b1;

  localparam logic [7:0] CODE_READ  = 8'h03;
  localparam logic [7:0] CODE_WRITE = 8'h06;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [2:0] {
    ST_READ_OK       = 3'd0,
    ST_WRITE_OK      = 3'd1,
    ST_CRC_ERR       = 3'd2,
    ST_BAD_COUNT     = 3'd3,
    ST_ADDR_MISMATCH = 3'd4
  } status_t;

  typedef struct packed {
    status_t    frame_status;
    logic [7:0] slave_address;
    logic [7:0] function_code;
    logic [7:0] first_data_byte;
  } result_t;

  // Reflected Modbus CRC-16, one byte, bit at a time.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/modbus_rtu_response_receiver.sv -----
// Modbus RTU response receiver: frame tracking, CRC-16 check and a two-deep
// result buffer. Depends on mbrx_pkg and assert_macros.svh.
//
// The block takes one received byte per beat, with the tick at which it arrived,
// and can take a beat on every clock cycle while s_tready is high. Each beat is
// handled in the cycle it is accepted: the frame state and running CRC update at
// that edge; a finished frame's result goes to the output register, visible on
// m_tvalid the next cycle, or to the skid entry if the output register holds a
// result not taken. s_tready falls only while both hold results, and rises again
// once the consumer takes a beat. Only the second CRC byte of a frame can produce
// a result, so at most one result per beat. Configuration writes take effect at
// the next edge and are expected only while the block is idle.
module modbus_rtu_response_receiver #(
  parameter int READ_DATA_LEN  = mbrx_pkg::ReadDataLenDefault,
  parameter int WRITE_DATA_LEN = mbrx_pkg::WriteDataLenDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  // config write port
  input  logic                           cfg_we,
  input  logic [mbrx_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [mbrx_pkg::CfgDataW-1:0]  cfg_data,
  // input beats
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [mbrx_pkg::InDataW-1:0]   s_tdata,  // [7:0] rx_byte, [39:8] arrival_tick
  // result beats
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [2:0] frame_status, [10:3] slave_address, [18:11] function_code,
  // [26:19] first_data_byte, [31:27] zero
  output logic [mbrx_pkg::OutDataW-1:0]  m_tdata
);
  import mbrx_pkg::*;

`include "assert_macros.svh"

  localparam logic [7:0] READ_TOTAL  = 8'(1 + READ_DATA_LEN);
  localparam logic [7:0] WRITE_TOTAL = 8'(WRITE_DATA_LEN);

  typedef enum logic [2:0] {
    PH_ADDR   = 3'd0,
    PH_CODE   = 3'd1,
    PH_DATA   = 3'd2,
    PH_CRC_LO = 3'd3,
    PH_CRC_HI = 3'd4
  } phase_t;

  // configuration
  logic [31:0] gap_timeout;
  logic [7:0]  device_address;
  logic [7:0]  expected_byte_count;
  logic        device_type_ok;

  // frame state
  phase_t      phase, phase_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_first_byte, crc_first_byte_next;
  logic [31:0] last_tick, last_tick_next;
  logic [7:0]  frame_address, frame_address_next;
  logic [7:0]  frame_code, frame_code_next;
  logic [7:0]  frame_first_data, frame_first_data_next;

  // result buffer
  logic        out_valid, skid_valid;
  result_t     out_res, skid_res;

  logic        accept, pop, push;
  logic [7:0]  rx_byte;
  logic [31:0] arrival_tick;
  logic [31:0] tick_delta;
  logic        gap;
  phase_t      cur_phase;
  logic [15:0] crc_upd;
  logic [7:0]  bytes_dec;
  logic [7:0]  data_total;
  result_t     new_res;
  logic        out_code_ok;
  logic        skid_stall;

  assign rx_byte      = s_tdata[7:0];
  assign arrival_tick = s_tdata[39:8];
  assign s_tready     = !skid_valid;
  assign accept       = s_tvalid && s_tready;
  assign m_tvalid     = out_valid;
  assign pop          = out_valid && m_tready;
  assign m_tdata      = {5'd0, out_res.first_data_byte, out_res.function_code,
                         out_res.slave_address, out_res.frame_status};

  assign tick_delta = arrival_tick - last_tick;
  assign gap        = tick_delta > gap_timeout;
  assign cur_phase  = gap ? PH_ADDR : phase;
  assign data_total = (frame_code == CODE_READ) ? READ_TOTAL : WRITE_TOTAL;
  assign bytes_dec  = (bytes_left != 8'd0) ? bytes_left - 8'd1 : bytes_left;
  // the address byte restarts the CRC
  assign crc_upd    = crc_feed((cur_phase == PH_ADDR) ? CRC_INIT : running_crc, rx_byte);

  always_comb begin
    phase_next            = phase;
    bytes_left_next       = bytes_left;
    running_crc_next      = running_crc;
    crc_first_byte_next   = crc_first_byte;
    last_tick_next        = last_tick;
    frame_address_next    = frame_address;
    frame_code_next       = frame_code;
    frame_first_data_next = frame_first_data;
    push                  = 1'b0;
    new_res.frame_status  = ST_CRC_ERR;
    if (accept) begin
      phase_next = cur_phase;
      unique case (cur_phase)
        PH_ADDR: begin
          // skip broadcast address
          if (rx_byte != 8'd0) begin
            frame_address_next = rx_byte;
            running_crc_next   = crc_upd;
            last_tick_next     = arrival_tick;
            phase_next         = PH_CODE;
          end
        end
        PH_CODE: begin
          if (rx_byte == CODE_READ || rx_byte == CODE_WRITE) begin
            frame_code_next  = rx_byte;
            running_crc_next = crc_upd;
            bytes_left_next  = (rx_byte == CODE_READ) ? READ_TOTAL : WRITE_TOTAL;
            last_tick_next   = arrival_tick;
            phase_next       = PH_DATA;
          end
        end
        PH_DATA: begin
          if (bytes_left == data_total) begin
            frame_first_data_next = rx_byte;
          end
          running_crc_next = crc_upd;
          last_tick_next   = arrival_tick;
          bytes_left_next  = bytes_dec;
          if (bytes_dec == 8'd0) begin
            phase_next = PH_CRC_LO;
          end
        end
        PH_CRC_LO: begin
          crc_first_byte_next = rx_byte;
          last_tick_next      = arrival_tick;
          phase_next          = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          last_tick_next = arrival_tick;
          phase_next     = PH_ADDR;
          if (crc_first_byte != running_crc[7:0] || rx_byte != running_crc[15:8]) begin
            new_res.frame_status = ST_CRC_ERR;
            push                 = 1'b1;
          end else if (frame_code == CODE_READ) begin
            // no report for reads unless the device type takes them
            new_res.frame_status = (frame_first_data == expected_byte_count) ?
                                   ST_READ_OK : ST_BAD_COUNT;
            push                 = device_type_ok;
          end else begin
            new_res.frame_status = (frame_address == device_address) ?
                                   ST_WRITE_OK : ST_ADDR_MISMATCH;
            push                 = 1'b1;
          end
        end
        default: begin
          phase_next = PH_ADDR;
        end
      endcase
    end
    new_res.slave_address   = frame_address;
    new_res.function_code   = frame_code;
    new_res.first_data_byte = frame_first_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_timeout         <= GAP_TIMEOUT_RESET;
      device_address      <= DEVICE_ADDRESS_RESET;
      expected_byte_count <= EXPECTED_COUNT_RESET;
      device_type_ok      <= DEVICE_TYPE_OK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAP_TIMEOUT:    gap_timeout         <= cfg_data;
        REG_DEVICE_ADDRESS: device_address      <= cfg_data[7:0];
        REG_EXPECTED_COUNT: expected_byte_count <= cfg_data[7:0];
        REG_DEVICE_TYPE_OK: device_type_ok      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_ADDR;
      bytes_left       <= 8'd0;
      running_crc      <= CRC_INIT;
      crc_first_byte   <= 8'd0;
      last_tick        <= 32'd0;
      frame_address    <= 8'd0;
      frame_code       <= 8'd0;
      frame_first_data <= 8'd0;
    end else begin
      phase            <= phase_next;
      bytes_left       <= bytes_left_next;
      running_crc      <= running_crc_next;
      crc_first_byte   <= crc_first_byte_next;
      last_tick        <= last_tick_next;
      frame_address    <= frame_address_next;
      frame_code       <= frame_code_next;
      frame_first_data <= frame_first_data_next;
    end
  end

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (out_valid) begin
      if (pop && push) begin
        out_res <= new_res;
      end else if (pop) begin
        out_valid <= 1'b0;
      end else if (push) begin
        skid_res   <= new_res;
        skid_valid <= 1'b1;
      end
    end else if (push) begin
      out_res   <= new_res;
      out_valid <= 1'b1;
    end
  end

  assign out_code_ok = (out_res.function_code == CODE_READ) ||
                       (out_res.function_code == CODE_WRITE);
  assign skid_stall  = skid_valid && !m_tready;

  `ASSERT_CLK_ALWAYS(a_skid_behind_out, skid_valid |-> out_valid, "skid entry without output")
  `ASSERT_CLK(a_push_ends_frame, push |=> phase == PH_ADDR, "frame not closed after result")
  `ASSERT_CLK(a_result_code, m_tvalid |-> out_code_ok, "result with unknown function code")
  `ASSERT_CLK(a_full_holds, skid_stall |=> (skid_valid && $stable(skid_res)), "queued result lost")

endmodule

// ----- tb/modbus_rtu_response_receiver_checker.sv -----
// Scoreboard for the Modbus RTU response receiver: tracks frames and CRC from the
// input beats, predicts each frame result and compares it with the result beats.
// Depends on mbrx_pkg.
module modbus_rtu_response_receiver_checker #(
  parameter int READ_DATA_LEN  = mbrx_pkg::ReadDataLenDefault,
  parameter int WRITE_DATA_LEN = mbrx_pkg::WriteDataLenDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mbrx_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [mbrx_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [mbrx_pkg::InDataW-1:0]   s_tdata,  // [7:0] rx_byte, [39:8] arrival_tick
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  // [2:0] frame_status, [10:3] slave_address, [18:11] function_code,
  // [26:19] first_data_byte
  input  logic [mbrx_pkg::OutDataW-1:0]  m_tdata,
  output int                             mismatches,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import mbrx_pkg::*;

  typedef enum logic [2:0] {
    PH_ADDR,
    PH_CODE,
    PH_DATA,
    PH_CRC_LO,
    PH_CRC_HI
  } rx_phase_t;

  localparam logic [7:0] READ_TOTAL  = 8'(READ_DATA_LEN + 1);
  localparam logic [7:0] WRITE_TOTAL = 8'(WRITE_DATA_LEN);

  logic [31:0] gap_limit;
  logic [7:0]  own_address;
  logic [7:0]  want_count;
  logic        valve_ok;

  rx_phase_t   phase;
  logic [7:0]  remaining;
  logic [15:0] crc_acc;
  logic [7:0]  crc_lo_seen;
  logic [31:0] stamp;
  logic [7:0]  cur_addr;
  logic [7:0]  cur_code;
  logic [7:0]  cur_first;

  result_t     frame_results[$];
  int          errors;

  // Shift the byte in one bit at a time, feedback from the low end.
  function automatic logic [15:0] crc16_modbus(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = r >> 1;
      if (fb) begin
        r = r ^ 16'hA001;
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] frame_length(input logic [7:0] code);
    return (code == CODE_READ) ? READ_TOTAL : WRITE_TOTAL;
  endfunction

  task automatic absorb(input logic [7:0] b, input logic [31:0] t);
    result_t     r;
    logic        report;
    logic [31:0] elapsed;
    report  = 1'b0;
    r       = '0;
    elapsed = t - stamp;
    if (elapsed > gap_limit) begin
      phase = PH_ADDR;
    end
    case (phase)
      PH_ADDR: begin
        // zero address is skipped and leaves the stamp alone
        if (b != 8'h00) begin
          cur_addr = b;
          crc_acc  = crc16_modbus(CRC_INIT, b);
          stamp    = t;
          phase    = PH_CODE;
        end
      end
      PH_CODE: begin
        if (b == CODE_READ || b == CODE_WRITE) begin
          cur_code  = b;
          crc_acc   = crc16_modbus(crc_acc, b);
          remaining = frame_length(b);
          stamp     = t;
          phase     = PH_DATA;
        end
      end
      PH_DATA: begin
        if (remaining == frame_length(cur_code)) begin
          cur_first = b;
        end
        crc_acc = crc16_modbus(crc_acc, b);
        stamp   = t;
        if (remaining != 0) begin
          remaining--;
        end
        if (remaining == 0) begin
          phase = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        crc_lo_seen = b;
        stamp       = t;
        phase       = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        stamp = t;
        phase = PH_ADDR;
        if (crc_lo_seen != crc_acc[7:0] || b != crc_acc[15:8]) begin
          r.frame_status = ST_CRC_ERR;
          report         = 1'b1;
        end else if (cur_code == CODE_READ) begin
          // reads from a device of the wrong type report nothing
          if (valve_ok) begin
            if (cur_first == want_count) begin
              r.frame_status = ST_READ_OK;
            end else begin
              r.frame_status = ST_BAD_COUNT;
            end
            report = 1'b1;
          end
        end else begin
          if (cur_addr == own_address) begin
            r.frame_status = ST_WRITE_OK;
          end else begin
            r.frame_status = ST_ADDR_MISMATCH;
          end
          report = 1'b1;
        end
      end
      default: begin
        phase = PH_ADDR;
      end
    endcase
    if (report) begin
      r.slave_address   = cur_addr;
      r.function_code   = cur_code;
      r.first_data_byte = cur_first;
      frame_results.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      gap_limit   = GAP_TIMEOUT_RESET;
      own_address = DEVICE_ADDRESS_RESET;
      want_count  = EXPECTED_COUNT_RESET;
      valve_ok    = DEVICE_TYPE_OK_RESET;
      phase       = PH_ADDR;
      remaining   = '0;
      crc_acc     = CRC_INIT;
      crc_lo_seen = '0;
      stamp       = '0;
      cur_addr    = '0;
      cur_code    = '0;
      cur_first   = '0;
      errors      = 0;
      frame_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (frame_results.size() == 0) begin
          if (errors < 10) begin
            $display("%0t: result beat with nothing expected: data %h", $realtime, m_tdata);
          end
          errors++;
        end else begin
          want = frame_results.pop_front();
          if (want.frame_status != m_tdata[2:0] || want.slave_address != m_tdata[10:3] ||
              want.function_code != m_tdata[18:11] || want.first_data_byte != m_tdata[26:19]) begin
            if (errors < 10) begin
              $display("%0t: result mismatch: status %0d/%0d addr %h/%h code %h/%h first %h/%h",
                       $realtime, want.frame_status, m_tdata[2:0], want.slave_address,
                       m_tdata[10:3], want.function_code, m_tdata[18:11],
                       want.first_data_byte, m_tdata[26:19]);
            end
            errors++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_GAP_TIMEOUT:    gap_limit   = cfg_data;
          REG_DEVICE_ADDRESS: own_address = cfg_data[7:0];
          REG_EXPECTED_COUNT: want_count  = cfg_data[7:0];
          REG_DEVICE_TYPE_OK: valve_ok    = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        absorb(s_tdata[7:0], s_tdata[39:8]);
      end
    end
    mismatches <= errors;
    pending    <= frame_results.size();
  end

endmodule

// ----- tb/tb_modbus_rtu_response_receiver.sv -----
// Top of the Modbus RTU response receiver testbench: clock, reset, register
// setup and byte traffic with idling. Depends on mbrx_pkg, the block and its checker.
module tb_modbus_rtu_response_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  import mbrx_pkg::*;

  localparam int READ_LEN    = ReadDataLenDefault;
  localparam int WRITE_LEN   = WriteDataLenDefault;
  localparam int STALL_LIMIT = 3000;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [InDataW-1:0]   s_tdata   = '0;  // [7:0] rx_byte, [39:8] arrival_tick
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  // [2:0] frame_status, [10:3] slave_address, [18:11] function_code,
  // [26:19] first_data_byte, [31:27] zero
  logic [OutDataW-1:0]  m_tdata;

  int          mismatch_total;
  int          pending;
  int          send_idle  = 0;
  int          recv_stall = 0;
  int          items_sent = 0;
  int          quiet_cycles;
  logic [31:0] now_tick;
  logic [31:0] gap_cfg;
  logic [7:0]  addr_cfg;
  logic [7:0]  count_cfg;

  modbus_rtu_response_receiver #(
    .READ_DATA_LEN (READ_LEN),
    .WRITE_DATA_LEN(WRITE_LEN)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  modbus_rtu_response_receiver_checker #(
    .READ_DATA_LEN (READ_LEN),
    .WRITE_DATA_LEN(WRITE_LEN)
  ) chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .mismatches(mismatch_total),
    .pending   (pending)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall);
  end

  // End the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_modbus_rtu_response_receiver failed");
        $finish;
      end
    end
  end

  // Frame CRC for building well-formed responses.
  function automatic logic [15:0] frame_crc(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    repeat (8) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  task automatic set_config(input logic [31:0] gap, input logic [7:0] addr,
                            input logic [7:0] count, input logic ok);
    logic [31:0] filler;
    filler    = $urandom;
    cfg_we    <= 1'b1;
    cfg_index <= REG_GAP_TIMEOUT;
    cfg_data  <= gap;
    @(posedge clk);
    // upper bits are junk on purpose: the block must mask them
    cfg_index <= REG_DEVICE_ADDRESS;
    cfg_data  <= {filler[31:8], addr};
    @(posedge clk);
    cfg_index <= REG_EXPECTED_COUNT;
    cfg_data  <= {filler[7:0], filler[31:16], count};
    @(posedge clk);
    cfg_index <= REG_DEVICE_TYPE_OK;
    cfg_data  <= {filler[31:1], ok};
    @(posedge clk);
    cfg_we    <= 1'b0;
    gap_cfg   = gap;
    addr_cfg  = addr;
    count_cfg = count;
  endtask

  task automatic send_beat(input logic [7:0] b, input logic [31:0] t);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {t, b};
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  // Advance the line tick: either a silence long enough to restart the frame,
  // or a step that stays within the timeout.
  task automatic step_tick(input bit restart);
    logic [31:0] span;
    if (restart && gap_cfg != 32'hFFFF_FFFF) begin
      span = gap_cfg + 32'd1;
      if (gap_cfg < 32'hFFFF_0000) begin
        span = span + $urandom_range(0, 1000);
      end
    end else if ($urandom_range(0, 19) == 0) begin
      span = gap_cfg;
    end else begin
      span = $urandom_range(0, (gap_cfg < 8) ? gap_cfg : 8);
    end
    now_tick = now_tick + span;
  endtask

  task automatic send_frame(input logic [7:0] code, input logic [7:0] addr,
                            input logic [7:0] lead, input bit corrupt, input bit junk,
                            input int cut_at);
    logic [7:0]  seq[$];
    logic [15:0] crc;
    logic [7:0]  odd_code;
    int          n_data;
    n_data = (code == CODE_READ) ? READ_LEN + 1 : WRITE_LEN;
    seq.push_back(addr);
    seq.push_back(code);
    seq.push_back(lead);
    for (int i = 1; i < n_data; i++) begin
      seq.push_back(8'($urandom));
    end
    crc = CRC_INIT;
    foreach (seq[i]) begin
      crc = frame_crc(crc, seq[i]);
    end
    if (corrupt) begin
      if ($urandom_range(0, 1) == 1) begin
        crc[7:0] = crc[7:0] ^ (8'h01 << $urandom_range(0, 7));
      end else begin
        crc[15:8] = crc[15:8] ^ (8'h01 << $urandom_range(0, 7));
      end
    end
    seq.push_back(crc[7:0]);
    seq.push_back(crc[15:8]);
    if (junk) begin
      do begin
        odd_code = 8'($urandom);
      end while (odd_code == CODE_READ || odd_code == CODE_WRITE);
      seq.insert(1, odd_code);
    end
    for (int i = 0; i < seq.size(); i++) begin
      if (cut_at != 0 && i == cut_at) begin
        break;
      end
      // the ignored code byte goes out at the address tick
      if (!(junk && i == 1)) begin
        step_tick(i == 0 && $urandom_range(0, 9) < 3);
      end
      send_beat(seq[i], now_tick);
    end
    if (cut_at != 0) begin
      step_tick(1'b1);
    end
  endtask

  task automatic random_traffic(input int quota);
    int         stop_at;
    int         pick;
    logic [7:0] code;
    logic [7:0] addr;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        if ($urandom_range(0, 3) != 0 && addr_cfg != 8'h00) begin
          addr = addr_cfg;
        end else begin
          addr = 8'($urandom_range(1, 255));
        end
        send_frame(CODE_WRITE, addr, 8'($urandom), $urandom_range(0, 9) == 0,
                   $urandom_range(0, 9) == 0, 0);
      end else if (pick < 72) begin
        send_frame(CODE_READ, 8'($urandom_range(1, 255)),
                   ($urandom_range(0, 6) != 0) ? count_cfg : 8'($urandom),
                   $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0, 0);
      end else if (pick < 85) begin
        // broken frame: stop part way, mostly on short writes
        code = ($urandom_range(0, 3) == 0) ? CODE_READ : CODE_WRITE;
        send_frame(code, 8'($urandom_range(1, 255)), count_cfg, 1'b0, 1'b0,
                   $urandom_range(1, ((code == CODE_READ) ? READ_LEN + 1 : WRITE_LEN) + 3));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          step_tick($urandom_range(0, 1) == 1);
          send_beat(8'($urandom), now_tick);
        end
      end
    end
  endtask

  // Drain: hold the input idle until every expected result is out.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  initial begin
    gap_cfg   = GAP_TIMEOUT_RESET;
    addr_cfg  = DEVICE_ADDRESS_RESET;
    count_cfg = EXPECTED_COUNT_RESET;
    now_tick  = 32'hFFFF_FFFC;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed frames at reset settings, ticks wrapping through zero
    send_beat(8'h00, now_tick);
    send_frame(CODE_WRITE, 8'h01, 8'hFF, 1'b0, 1'b1, 0);
    send_frame(CODE_WRITE, 8'hFF, 8'h00, 1'b0, 1'b0, 0);
    send_frame(CODE_WRITE, 8'h01, 8'h12, 1'b0, 1'b0, 3);
    send_frame(CODE_WRITE, 8'h01, 8'h34, 1'b1, 1'b0, 0);
    random_traffic(180);

    settle();
    set_config(32'd0, 8'hFF, 8'h00, 1'b0);
    send_idle = 75;
    now_tick  = $urandom;
    random_traffic(200);

    settle();
    set_config(32'hFFFF_FFFF, 8'h00, 8'hFF, 1'b1);
    send_idle  = 0;
    recv_stall = 75;
    now_tick   = $urandom;
    random_traffic(200);

    settle();
    set_config($urandom_range(1, 1000), 8'($urandom_range(1, 255)), 8'($urandom), 1'b1);
    send_idle  = 29;
    recv_stall = 29;
    now_tick   = $urandom;
    random_traffic(200);

    settle();
    if (mismatch_total == 0) begin
      $display("tb_modbus_rtu_response_receiver passed");
    end else begin
      $display("tb_modbus_rtu_response_receiver failed");
    end
    $finish;
  end

endmodule
